@@ rtl/frp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_pkg
// Types and constants shared by the file record response parser.
// ----------------------------------------------------------------------------
package frp_pkg;

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_COUNT = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_REF   = 6'b000100,
        PH_HIGH  = 6'b001000,
        PH_LOW   = 6'b010000,
        PH_DROP  = 6'b100000
    } phase_t;

    localparam logic [7:0] REF_TYPE_FILE = 8'd6;
    localparam logic [8:0] SEEN_MAX      = 9'd511;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_REF  = 2'd1;
    localparam logic [1:0] ST_OVERRUN  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    typedef struct packed {
        logic        word_valid;
        logic [6:0]  sub_index;
        logic [6:0]  word_offset;
        logic [15:0] word_value;
        logic        done_res;
        logic [1:0]  status;
    } frp_result_t;

endpackage

@@ rtl/frp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frp_core
// Parser state and per-byte step logic; state advances when en is high.
// ----------------------------------------------------------------------------
module frp_core import frp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        has_result,
    output frp_result_t result
);

    phase_t      phase_reg,    phase_next;
    logic [7:0]  declared_reg, declared_next;
    logic [8:0]  seen_reg,     seen_next;
    logic [7:0]  left_reg,     left_next;
    logic [6:0]  sub_reg,      sub_next;
    logic [6:0]  word_reg,     word_next;
    logic [7:0]  high_reg,     high_next;
    logic [1:0]  err_reg,      err_next;

    logic [9:0]  len_sum;
    logic        word_done;
    logic [1:0]  final_status;

    always_comb begin
        phase_next    = phase_reg;
        declared_next = declared_reg;
        seen_next     = seen_reg;
        left_next     = left_reg;
        sub_next      = sub_reg;
        word_next     = word_reg;
        high_next     = high_reg;
        err_next      = err_reg;
        word_done     = 1'b0;
        final_status  = ST_OK;

        if (phase_reg != PH_COUNT && seen_reg != SEEN_MAX) begin
            seen_next = seen_reg + 9'd1;
        end
        len_sum = {1'b0, seen_next} + {2'b00, data_byte};

        unique case (phase_reg)
            PH_COUNT: begin
                declared_next = data_byte;
                seen_next     = 9'd0;
                phase_next    = PH_LEN;
            end
            PH_LEN: begin
                if (data_byte == 8'd0 || len_sum > {2'b00, declared_reg}) begin
                    err_next   = ST_OVERRUN;
                    phase_next = PH_DROP;
                end else begin
                    left_next  = data_byte - 8'd1;
                    phase_next = PH_REF;
                end
            end
            PH_REF: begin
                if (data_byte != REF_TYPE_FILE) begin
                    err_next   = ST_BAD_REF;
                    phase_next = PH_DROP;
                end else begin
                    word_next  = 7'd0;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH: begin
                high_next  = data_byte;
                left_next  = left_reg - 8'd1;
                phase_next = PH_LOW;
            end
            PH_LOW: begin
                word_done  = 1'b1;
                word_next  = word_reg + 7'd1;
                left_next  = left_reg - 8'd1;
                phase_next = PH_HIGH;
            end
            default: begin
                // drop bytes
            end
        endcase

        // close the sub-response once its bytes are used up
        if ((phase_reg == PH_REF && data_byte == REF_TYPE_FILE)
                || phase_reg == PH_HIGH || phase_reg == PH_LOW) begin
            if (left_next == 8'd0) begin
                sub_next   = sub_reg + 7'd1;
                phase_next = PH_LEN;
            end
        end

        if (last_byte) begin
            if (err_next != ST_OK) begin
                final_status = err_next;
            end else if (seen_next != {1'b0, declared_next}) begin
                final_status = ST_MISMATCH;
            end
            // return to the start for the next response
            phase_next    = PH_COUNT;
            declared_next = 8'd0;
            seen_next     = 9'd0;
            left_next     = 8'd0;
            sub_next      = 7'd0;
            word_next     = 7'd0;
            high_next     = 8'd0;
            err_next      = ST_OK;
        end
    end

    assign has_result         = word_done || last_byte;
    assign result.word_valid  = word_done;
    assign result.sub_index   = word_done ? sub_reg : 7'd0;
    assign result.word_offset = word_done ? word_reg : 7'd0;
    assign result.word_value  = word_done ? {high_reg, data_byte} : 16'd0;
    assign result.done_res    = last_byte;
    assign result.status      = final_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_COUNT;
            declared_reg <= 8'd0;
            seen_reg     <= 9'd0;
            left_reg     <= 8'd0;
            sub_reg      <= 7'd0;
            word_reg     <= 7'd0;
            high_reg     <= 8'd0;
            err_reg      <= ST_OK;
        end else if (en) begin
            phase_reg    <= phase_next;
            declared_reg <= declared_next;
            seen_reg     <= seen_next;
            left_reg     <= left_next;
            sub_reg      <= sub_next;
            word_reg     <= word_next;
            high_reg     <= high_next;
            err_reg      <= err_next;
        end
    end

endmodule

@@ rtl/file_record_response_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_record_response_parser
// Parses the data field of a read-file-record response one byte per item
// and emits completed record words and a final status item.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  s_       | s_valid s_ready s_data_byte s_last_byte | in
//  m_       | m_valid m_ready m_word_valid m_sub_index| out
//           | m_word_offset m_word_value m_done_res   |
//           | m_status                               |
//
// One byte per cycle sustained while m_ does not stall: an item is held in
// the input register, then the step logic writes the result register.
// m_valid rises once the step has written a byte's result into the result
// register. Bytes that cause no result still pass through the step.
// Reset (aresetn low) empties both registers and returns the parser to the
// byte count phase; a stall on m_ stops the step only for bytes with results.
// ----------------------------------------------------------------------------
module file_record_response_parser import frp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_word_valid,
    output logic [6:0]  m_sub_index,
    output logic [6:0]  m_word_offset,
    output logic [15:0] m_word_value,
    output logic        m_done_res,
    output logic [1:0]  m_status
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    frp_result_t out_reg;

    logic        advance;
    logic        core_has_result;
    frp_result_t core_result;

    frp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .data_byte  (in_data_reg),
        .last_byte  (in_last_reg),
        .has_result (core_has_result),
        .result     (core_result)
    );

    // hold the byte only when its result has nowhere to go
    assign advance = in_valid_reg && (!core_has_result || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && core_has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_has_result) begin
            out_reg <= core_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_word_valid  = out_reg.word_valid;
    assign m_sub_index   = out_reg.sub_index;
    assign m_word_offset = out_reg.word_offset;
    assign m_word_value  = out_reg.word_value;
    assign m_done_res    = out_reg.done_res;
    assign m_status      = out_reg.status;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word_valid || m_done_res))
        else $error("result item carries neither word nor done");

    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> m_done_res)
        else $error("nonzero status without done");

    a_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word_valid) |->
            (m_word_value == 16'd0 && m_sub_index == 7'd0 && m_word_offset == 7'd0))
        else $error("word fields nonzero without a word");

endmodule
